@@ hdl/hsv2rgb_pkg.sv @@
// Shared types, constants and fixed-point helpers for the HSV to RGB pixel converter.
package hsv2rgb_pkg;

    // Full-scale color level (1.0) and its product with a 0.16 unit fraction.
    localparam logic [7:0]  FULL_LEVEL = 8'd255;
    localparam logic [23:0] FULL_FRAC  = 24'd255 << 16;
    localparam logic [16:0] FRAC_ONE   = 17'h10000;

    // Input beat: one HSV pixel.
    typedef struct packed {
        logic [15:0] hue;
        logic [7:0]  saturation;
        logic [7:0]  brightness;
    } hsv_pixel_t;

    // Output beat: one RGB pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_pixel_t;

    // Color wheel sector, the integer part of hue times six.
    typedef enum logic [2:0] {
        SECTOR_RED_YELLOW     = 3'd0,
        SECTOR_YELLOW_GREEN   = 3'd1,
        SECTOR_GREEN_CYAN     = 3'd2,
        SECTOR_CYAN_BLUE      = 3'd3,
        SECTOR_BLUE_MAGENTA   = 3'd4,
        SECTOR_MAGENTA_RED    = 3'd5
    } sector_t;

    // The four levels that the sector router distributes.
    typedef struct packed {
        logic [7:0] v;
        logic [7:0] p;
        logic [7:0] q;
        logic [7:0] t;
    } levels_t;

    // First guess of x / 255 as x * 257 / 65536; it is exact or one too small.
    function automatic logic [7:0] div255_estimate(input logic [15:0] x);
        logic [24:0] sum;
        sum = {9'd0, x} + {1'b0, x, 8'd0};
        return sum[23:16];
    endfunction

    // Final x / 255 from the guess: one compare on the remainder.
    function automatic logic [7:0] div255_correct(input logic [15:0] x,
                                                   input logic [7:0]  est);
        logic [16:0] prod;
        logic [16:0] rem;
        prod = {1'b0, est, 8'd0} - {9'd0, est};
        rem  = {1'b0, x} - prod;
        return (rem >= {9'd0, FULL_LEVEL}) ? est + 8'd1 : est;
    endfunction

endpackage

@@ hdl/hsv_to_rgb_pixel_converter.sv @@
// Top level of the HSV to RGB pixel converter: six-stage pipeline with stall control.
//
//   Port group  Dir  Handshake               Beat
//   hsv         in   hsv_valid / hsv_ready   hsv_pixel_t (hue, saturation, brightness)
//   rgb         out  rgb_valid / rgb_ready   rgb_pixel_t (red, green, blue)
//
// One pixel is taken every clock cycle unless rgb_ready holds off a full pipeline.
// Six register stages: sector and p product, s*f products, v products,
// divide-by-255 guess, divide-by-255 fix, sector routing into the output register.
// Reset clears only the stage valid bits; the data registers are not reset.
// A stage loads whenever it is empty or the stage after it moves, so bubbles
// are squeezed out and input stalls only when every stage holds a pixel.
// Zero saturation needs no special path: p, q and t all equal v there.
module hsv_to_rgb_pixel_converter (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    hsv_valid,
    output logic                    hsv_ready,
    input  hsv2rgb_pkg::hsv_pixel_t hsv,
    output logic                    rgb_valid,
    input  logic                    rgb_ready,
    output hsv2rgb_pkg::rgb_pixel_t rgb
);

    // Stage valid bits and load enables.
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg, s6_vld_reg;
    logic ld1, ld2, ld3, ld4, ld5, ld6;

    // Stage 1: sector, fraction, inputs, p numerator.
    hsv2rgb_pkg::sector_t s1_sector_reg, s1_sector_next;
    logic [15:0] s1_frac_reg, s1_frac_next;
    logic [7:0]  s1_sat_reg, s1_sat_next;
    logic [7:0]  s1_val_reg, s1_val_next;
    logic [15:0] s1_pnum_reg, s1_pnum_next;

    // Stage 2: q and t factors.
    hsv2rgb_pkg::sector_t s2_sector_reg;
    logic [7:0]  s2_val_reg;
    logic [15:0] s2_pnum_reg;
    logic [23:0] s2_qfac_reg, s2_qfac_next;
    logic [23:0] s2_tfac_reg, s2_tfac_next;

    // Stage 3: upper halves of the q and t numerators.
    hsv2rgb_pkg::sector_t s3_sector_reg;
    logic [7:0]  s3_val_reg;
    logic [15:0] s3_pnum_reg;
    logic [15:0] s3_qnum_reg, s3_qnum_next;
    logic [15:0] s3_tnum_reg, s3_tnum_next;

    // Stage 4: quotient guesses.
    hsv2rgb_pkg::sector_t s4_sector_reg;
    logic [7:0]  s4_val_reg;
    logic [15:0] s4_pnum_reg, s4_qnum_reg, s4_tnum_reg;
    logic [7:0]  s4_pest_reg, s4_pest_next;
    logic [7:0]  s4_qest_reg, s4_qest_next;
    logic [7:0]  s4_test_reg, s4_test_next;

    // Stage 5: final levels.
    hsv2rgb_pkg::sector_t s5_sector_reg;
    hsv2rgb_pkg::levels_t s5_levels_reg, s5_levels_next;

    // Stage 6: output pixel.
    hsv2rgb_pkg::rgb_pixel_t s6_rgb_reg, s6_rgb_next;

    // Product temporaries.
    logic [18:0] hue_x6;
    logic [23:0] sat_frac;
    logic [16:0] frac_rest;
    logic [24:0] sat_rest;
    logic [31:0] qprod;
    logic [31:0] tprod;

    // Backpressure: a stage loads when empty or when its successor loads.
    assign ld6       = !s6_vld_reg || rgb_ready;
    assign ld5       = !s5_vld_reg || ld6;
    assign ld4       = !s4_vld_reg || ld5;
    assign ld3       = !s3_vld_reg || ld4;
    assign ld2       = !s2_vld_reg || ld3;
    assign ld1       = !s1_vld_reg || ld2;
    assign hsv_ready = ld1;

    // Stage 1: hue times six by shift and add, and the p numerator v*(255-s).
    always_comb
    begin
        hue_x6         = {1'b0, hsv.hue, 2'b00} + {2'b00, hsv.hue, 1'b0};
        s1_sector_next = hsv2rgb_pkg::sector_t'(hue_x6[18:16]);
        s1_frac_next   = hue_x6[15:0];
        s1_sat_next    = hsv.saturation;
        s1_val_next    = hsv.brightness;
        s1_pnum_next   = {8'd0, hsv.brightness}
                       * {8'd0, hsv2rgb_pkg::FULL_LEVEL - hsv.saturation};
    end

    // Stage 2: s*f and s*(1-f), each taken from full scale.
    always_comb
    begin
        sat_frac     = {16'd0, s1_sat_reg} * {8'd0, s1_frac_reg};
        frac_rest    = hsv2rgb_pkg::FRAC_ONE - {1'b0, s1_frac_reg};
        sat_rest     = {17'd0, s1_sat_reg} * {8'd0, frac_rest};
        s2_qfac_next = hsv2rgb_pkg::FULL_FRAC - sat_frac;
        s2_tfac_next = hsv2rgb_pkg::FULL_FRAC - sat_rest[23:0];
    end

    // Stage 3: v times each factor; dropping the low 16 bits is the first floor.
    always_comb
    begin
        qprod        = {24'd0, s2_val_reg} * {8'd0, s2_qfac_reg};
        tprod        = {24'd0, s2_val_reg} * {8'd0, s2_tfac_reg};
        s3_qnum_next = qprod[31:16];
        s3_tnum_next = tprod[31:16];
    end

    // Stage 4: reciprocal guesses of each numerator over 255.
    always_comb
    begin
        s4_pest_next = hsv2rgb_pkg::div255_estimate(s3_pnum_reg);
        s4_qest_next = hsv2rgb_pkg::div255_estimate(s3_qnum_reg);
        s4_test_next = hsv2rgb_pkg::div255_estimate(s3_tnum_reg);
    end

    // Stage 5: remainder check fixes each guess.
    always_comb
    begin
        s5_levels_next.v = s4_val_reg;
        s5_levels_next.p = hsv2rgb_pkg::div255_correct(s4_pnum_reg, s4_pest_reg);
        s5_levels_next.q = hsv2rgb_pkg::div255_correct(s4_qnum_reg, s4_qest_reg);
        s5_levels_next.t = hsv2rgb_pkg::div255_correct(s4_tnum_reg, s4_test_reg);
    end

    // Stage 6: route levels to channels.
    hsv2rgb_sector_route u_route (
        .sector (s5_sector_reg),
        .levels (s5_levels_reg),
        .pixel  (s6_rgb_next)
    );

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                s1_vld_reg <= hsv_valid;
            end
            if (ld2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (ld3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (ld4)
            begin
                s4_vld_reg <= s3_vld_reg;
            end
            if (ld5)
            begin
                s5_vld_reg <= s4_vld_reg;
            end
            if (ld6)
            begin
                s6_vld_reg <= s5_vld_reg;
            end
        end
    end

    // Data registers, loaded with their stage.
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_sector_reg <= s1_sector_next;
            s1_frac_reg   <= s1_frac_next;
            s1_sat_reg    <= s1_sat_next;
            s1_val_reg    <= s1_val_next;
            s1_pnum_reg   <= s1_pnum_next;
        end
        if (ld2)
        begin
            s2_sector_reg <= s1_sector_reg;
            s2_val_reg    <= s1_val_reg;
            s2_pnum_reg   <= s1_pnum_reg;
            s2_qfac_reg   <= s2_qfac_next;
            s2_tfac_reg   <= s2_tfac_next;
        end
        if (ld3)
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_val_reg    <= s2_val_reg;
            s3_pnum_reg   <= s2_pnum_reg;
            s3_qnum_reg   <= s3_qnum_next;
            s3_tnum_reg   <= s3_tnum_next;
        end
        if (ld4)
        begin
            s4_sector_reg <= s3_sector_reg;
            s4_val_reg    <= s3_val_reg;
            s4_pnum_reg   <= s3_pnum_reg;
            s4_qnum_reg   <= s3_qnum_reg;
            s4_tnum_reg   <= s3_tnum_reg;
            s4_pest_reg   <= s4_pest_next;
            s4_qest_reg   <= s4_qest_next;
            s4_test_reg   <= s4_test_next;
        end
        if (ld5)
        begin
            s5_sector_reg <= s4_sector_reg;
            s5_levels_reg <= s5_levels_next;
        end
        if (ld6)
        begin
            s6_rgb_reg <= s6_rgb_next;
        end
    end

    assign rgb_valid = s6_vld_reg;
    assign rgb       = s6_rgb_reg;

`ifndef NO_ASSERTIONS
    // Levels derived from v never exceed v.
    a_levels_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        s5_vld_reg |-> (s5_levels_reg.p <= s5_levels_reg.v
                     && s5_levels_reg.q <= s5_levels_reg.v
                     && s5_levels_reg.t <= s5_levels_reg.v))
        else $error("derived level above v");

    // Input stalls only when every stage is occupied.
    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !hsv_ready |-> (s1_vld_reg && s2_vld_reg && s3_vld_reg
                     && s4_vld_reg && s5_vld_reg && s6_vld_reg))
        else $error("input stalled with a bubble in the pipeline");

    // A held stage keeps its pixel.
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_vld_reg && !ld4) |=> (s3_vld_reg && $stable(s3_qnum_reg)))
        else $error("stalled stage lost its pixel");
`endif

endmodule

@@ hdl/hsv2rgb_sector_route.sv @@
// Sector router: places v, p, q and t on the red, green and blue channels.
module hsv2rgb_sector_route (
    input  hsv2rgb_pkg::sector_t    sector,
    input  hsv2rgb_pkg::levels_t    levels,
    output hsv2rgb_pkg::rgb_pixel_t pixel
);

    // Each sector has one channel at v, one at p and one ramping through q or t.
    always_comb
    begin
        case (sector)
            hsv2rgb_pkg::SECTOR_RED_YELLOW:
            begin
                pixel.red   = levels.v;
                pixel.green = levels.t;
                pixel.blue  = levels.p;
            end
            hsv2rgb_pkg::SECTOR_YELLOW_GREEN:
            begin
                pixel.red   = levels.q;
                pixel.green = levels.v;
                pixel.blue  = levels.p;
            end
            hsv2rgb_pkg::SECTOR_GREEN_CYAN:
            begin
                pixel.red   = levels.p;
                pixel.green = levels.v;
                pixel.blue  = levels.t;
            end
            hsv2rgb_pkg::SECTOR_CYAN_BLUE:
            begin
                pixel.red   = levels.p;
                pixel.green = levels.q;
                pixel.blue  = levels.v;
            end
            hsv2rgb_pkg::SECTOR_BLUE_MAGENTA:
            begin
                pixel.red   = levels.t;
                pixel.green = levels.p;
                pixel.blue  = levels.v;
            end
            default:
            begin
                pixel.red   = levels.v;
                pixel.green = levels.p;
                pixel.blue  = levels.q;
            end
        endcase
    end

endmodule

@@ bench/tb_top.sv @@
// Testbench for the HSV to RGB pixel converter: directed and random pixels against a predictor.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 1630;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 60;
    localparam int MAX_PRINTED  = 20;

    logic                    clk;
    logic                    rst_n;
    logic                    hsv_valid = 1'b0;
    logic                    hsv_ready;
    hsv2rgb_pkg::hsv_pixel_t hsv_beat  = '0;
    logic                    rgb_valid;
    logic                    rgb_ready = 1'b0;
    hsv2rgb_pkg::rgb_pixel_t rgb_beat;

    hsv2rgb_pkg::hsv_pixel_t hsv_pending[$];
    hsv2rgb_pkg::rgb_pixel_t rgb_expected[$];

    int          error_count    = 0;
    int          received_count = 0;
    int          sent_count     = 0;
    int          grey_count     = 0;
    int          sector_hits[6] = '{default: 0};
    int          send_gap       = 0;
    int          recv_gap       = 0;
    int          hold_left      = 0;
    int          hold_count     = 0;
    int          idle_cycles    = 0;
    int unsigned cycle_count    = 0;
    hsv2rgb_pkg::rgb_pixel_t want;

    hsv_to_rgb_pixel_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .hsv_valid (hsv_valid),
        .hsv_ready (hsv_ready),
        .hsv       (hsv_beat),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb       (rgb_beat)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Expected RGB pixel for one HSV pixel, computed at full width and floored.
    function automatic hsv2rgb_pkg::rgb_pixel_t hsv_to_rgb(input hsv2rgb_pkg::hsv_pixel_t px);
        logic [63:0] hue64;
        logic [63:0] sat64;
        logic [63:0] val64;
        logic [63:0] scaled;
        logic [63:0] frac;
        logic [63:0] denom;
        logic [63:0] lvl_p;
        logic [63:0] lvl_q;
        logic [63:0] lvl_t;
        hsv2rgb_pkg::sector_t    sector;
        hsv2rgb_pkg::rgb_pixel_t out;
        hue64  = {48'd0, px.hue};
        sat64  = {56'd0, px.saturation};
        val64  = {56'd0, px.brightness};
        if (sat64 == 64'd0)
        begin
            out.red   = px.brightness;
            out.green = px.brightness;
            out.blue  = px.brightness;
            grey_count++;
            return out;
        end
        scaled = hue64 * 64'd6;
        sector = hsv2rgb_pkg::sector_t'(scaled[18:16]);
        frac   = {48'd0, scaled[15:0]};
        denom  = 64'd255 * 64'd65536;
        lvl_p  = (val64 * (64'd255 - sat64)) / 64'd255;
        lvl_q  = (val64 * (denom - sat64 * frac)) / denom;
        lvl_t  = (val64 * (denom - sat64 * (64'd65536 - frac))) / denom;
        sector_hits[scaled[18:16]]++;
        case (sector)
            hsv2rgb_pkg::SECTOR_RED_YELLOW:   out = {px.brightness, lvl_t[7:0], lvl_p[7:0]};
            hsv2rgb_pkg::SECTOR_YELLOW_GREEN: out = {lvl_q[7:0], px.brightness, lvl_p[7:0]};
            hsv2rgb_pkg::SECTOR_GREEN_CYAN:   out = {lvl_p[7:0], px.brightness, lvl_t[7:0]};
            hsv2rgb_pkg::SECTOR_CYAN_BLUE:    out = {lvl_p[7:0], lvl_q[7:0], px.brightness};
            hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: out = {lvl_t[7:0], lvl_p[7:0], px.brightness};
            default:                          out = {px.brightness, lvl_p[7:0], lvl_q[7:0]};
        endcase
        return out;
    endfunction

    // Hue at which sector k begins: the smallest hue with hue*6 >= k*65536.
    function automatic logic [15:0] sector_start(input int k);
        return 16'((k * 65536 + 5) / 6);
    endfunction

    // Random hue that favors the turn ends and the sector edges.
    function automatic logic [15:0] pick_hue();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel < 2)
            return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        if (sel < 4)
            return sector_start($urandom_range(1, 5)) + 16'($urandom_range(0, 4)) - 16'd2;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Random 8-bit level that favors zero and full scale.
    function automatic logic [7:0] pick_level();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel < 2)
            return 8'd0;
        if (sel < 4)
            return 8'd255;
        return 8'($urandom_range(0, 255));
    endfunction

    // Idle length: usually none or short, now and then long; none while cycle_count[10:9] is 2'b11.
    function automatic int pick_gap();
        int sel;
        if (cycle_count[10:9] == 2'b11)
            return 0;
        sel = $urandom_range(0, 99);
        if (sel < 55)
            return 0;
        if (sel < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Prints one line per mismatch, up to a cap, and counts every one.
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("[%0t] MISMATCH %s: got %0d, expected %0d (pixel %0d)",
                     $realtime, what, got, exp_val, received_count);
    endtask

    // Driver: offers queued pixels with random gaps and records each accepted beat.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsv_valid <= 1'b0;
            hsv_beat  <= '0;
        end
        else
        begin
            if (hsv_valid && hsv_ready)
            begin
                rgb_expected.push_back(hsv_to_rgb(hsv_beat));
                sent_count++;
            end
            if (!hsv_valid || hsv_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    hsv_valid <= 1'b0;
                end
                else if (hsv_pending.size() > 0)
                begin
                    hsv_beat  <= hsv_pending.pop_front();
                    hsv_valid <= 1'b1;
                    send_gap   = pick_gap();
                end
                else
                begin
                    hsv_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each output beat and drives ready with random stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_ready <= 1'b0;
        end
        else
        begin
            if (rgb_valid && rgb_ready)
            begin
                if (rgb_expected.size() == 0)
                begin
                    report_mismatch("unexpected beat", 32'(rgb_beat), 32'd0);
                end
                else
                begin
                    want = rgb_expected.pop_front();
                    if (rgb_beat.red !== want.red)
                        report_mismatch("red", 32'(rgb_beat.red), 32'(want.red));
                    if (rgb_beat.green !== want.green)
                        report_mismatch("green", 32'(rgb_beat.green), 32'(want.green));
                    if (rgb_beat.blue !== want.blue)
                        report_mismatch("blue", 32'(rgb_beat.blue), 32'(want.blue));
                end
                received_count++;
                // Long back-pressure now and then so the pipeline fills and stalls input.
                if (received_count % 500 == 250)
                begin
                    hold_left = HOLD_CYCLES;
                    hold_count++;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rgb_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                rgb_ready <= 1'b0;
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                    recv_gap = pick_gap();
                rgb_ready <= (recv_gap == 0);
            end
        end
    end

    // Watchdog: ends the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        cycle_count++;
        if (!rst_n || (hsv_valid && hsv_ready) || (rgb_valid && rgb_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial
    begin
        hsv2rgb_pkg::hsv_pixel_t px;
        rst_n = 1'b0;

        // Directed: turn ends, a grey and a black pixel, both sides of every sector edge, and sector midpoints.
        hsv_pending.push_back('{16'h0000, 8'd255, 8'd255});
        hsv_pending.push_back('{16'hFFFF, 8'd255, 8'd255});
        hsv_pending.push_back('{16'h7530, 8'd0,   8'd200});
        hsv_pending.push_back('{16'h7530, 8'd200, 8'd0});
        for (int k = 1; k < 6; k++)
        begin
            hsv_pending.push_back('{sector_start(k) - 16'd1, 8'd255, 8'd255});
            hsv_pending.push_back('{sector_start(k), 8'd255, 8'd255});
        end
        for (int k = 0; k < 6; k++)
            hsv_pending.push_back('{sector_start(k) + 16'd5461, 8'd128, 8'd200});

        // Random pixels with extremes weighted up.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            px.hue        = pick_hue();
            px.saturation = pick_level();
            px.brightness = pick_level();
            hsv_pending.push_back(px);
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for all pixels to go in, then for all results to come out.
        while (hsv_pending.size() > 0 || hsv_valid)
            @(posedge clk);
        while (rgb_expected.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (rgb_expected.size() > 0)
            report_mismatch("missing beats", 32'd0, 32'(rgb_expected.size()));

        $display("Converted %0d pixels (%0d checked); %0d grey, %0d output hold-offs.",
                 sent_count, received_count, grey_count, hold_count);
        $display("Sector hits: %0d %0d %0d %0d %0d %0d; %0d mismatches.",
                 sector_hits[0], sector_hits[1], sector_hits[2],
                 sector_hits[3], sector_hits[4], sector_hits[5], error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
hdl/hsv2rgb_pkg.sv
hdl/hsv2rgb_sector_route.sv
hdl/hsv_to_rgb_pixel_converter.sv
bench/tb_top.sv
